// ===== design/mvd_pkg.sv =====
`default_nettype none

package mvd_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int INDEX_BITS  = 20;
   localparam int NORMAL_BITS = 32;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int VIDX_BITS   = 10;
   localparam int VCNT_BITS   = 11;
   localparam int MODE_BITS   = 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_WORD_BITS = 1;

   localparam logic [CSR_WORD_BITS-1:0] REG_MATCH_MODE = 1'b0;

   localparam logic [MODE_BITS-1:0] MODE_POS     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_POS_UV  = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  pos;
      logic [INDEX_BITS-1:0]  uv;
      logic [NORMAL_BITS-1:0] nx;
      logic [NORMAL_BITS-1:0] ny;
      logic [NORMAL_BITS-1:0] nz;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic match;
      logic pending;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/mesh_vertex_deduplicator_unit.sv =====
// mesh vertex deduplicator
// req channel: one face corner per request (position index, texture index,
// normal bit patterns, last-of-mesh flag); taken when req_valid is high and
// req_stall is low. req_stall is high from acceptance until the result has
// been handed to the output register.
// rsp channel: one result per request (vertex number, new flag, table-full
// flag, vertex count); taken when rsp_valid is high and rsp_stall is low.
// the lookup walks the entry table one stored vertex per cycle through a
// single read port with registered data, stopping at the first match.
// when rsp_stall holds a result, the next request's scan still runs and it
// waits only to load the output register.
// csr port: match_mode at byte address 0; the user must write it only while
// the block is idle, which the block itself does not enforce. reset clears
// the entry count, match_mode and all handshake state; the table contents
// are not cleared. last_of_mesh empties the table after its result.
`default_nettype none

module mesh_vertex_deduplicator_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire [mvd_pkg::INDEX_BITS-1:0]         req_pos_index,
   input  wire [mvd_pkg::INDEX_BITS-1:0]         req_uv_index,
   input  wire [mvd_pkg::NORMAL_BITS-1:0]        req_normal_x,
   input  wire [mvd_pkg::NORMAL_BITS-1:0]        req_normal_y,
   input  wire [mvd_pkg::NORMAL_BITS-1:0]        req_normal_z,
   input  wire                                   req_last_of_mesh,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [mvd_pkg::VIDX_BITS-1:0]         rsp_vertex_index,
   output logic                                  rsp_new_vertex,
   output logic                                  rsp_table_full,
   output logic [mvd_pkg::VCNT_BITS-1:0]         rsp_vertex_count,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire [mvd_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  wire [mvd_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [mvd_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import mvd_pkg::*;

   logic [MODE_BITS-1:0]     mode_ff;
   logic [MODE_BITS-1:0]     mode_in;
   logic [CSR_WORD_BITS-1:0] csr_word;
   logic                     csr_wr;
   dp_cmd_type               cmd;
   dp_status_type            status;

   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && (csr_word == REG_MATCH_MODE)) begin
         mode_in = csr_pwdata[MODE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_word)
         REG_MATCH_MODE: csr_prdata = CSR_DATA_BITS'(mode_ff);
         default:        csr_prdata = '0;
      endcase
   end

   mvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mvd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .match_mode       (mode_ff),
      .req_pos_index    (req_pos_index),
      .req_uv_index     (req_uv_index),
      .req_normal_x     (req_normal_x),
      .req_normal_y     (req_normal_y),
      .req_normal_z     (req_normal_z),
      .req_last_of_mesh (req_last_of_mesh),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_new_vertex   (rsp_new_vertex),
      .rsp_table_full   (rsp_table_full),
      .rsp_vertex_count (rsp_vertex_count)
   );

endmodule

`default_nettype wire

// ===== design/mvd_ctrl.sv =====
`default_nettype none

module mvd_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  mvd_pkg::dp_status_type    status,
   output mvd_pkg::dp_cmd_type       cmd
);
   import mvd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match || !status.pending) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/mvd_datapath.sv =====
`default_nettype none

module mvd_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  mvd_pkg::dp_cmd_type                   cmd,
   output mvd_pkg::dp_status_type                status,
   input  wire [mvd_pkg::MODE_BITS-1:0]          match_mode,
   input  wire [mvd_pkg::INDEX_BITS-1:0]         req_pos_index,
   input  wire [mvd_pkg::INDEX_BITS-1:0]         req_uv_index,
   input  wire [mvd_pkg::NORMAL_BITS-1:0]        req_normal_x,
   input  wire [mvd_pkg::NORMAL_BITS-1:0]        req_normal_y,
   input  wire [mvd_pkg::NORMAL_BITS-1:0]        req_normal_z,
   input  wire                                   req_last_of_mesh,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [mvd_pkg::VIDX_BITS-1:0]         rsp_vertex_index,
   output logic                                  rsp_new_vertex,
   output logic                                  rsp_table_full,
   output logic [mvd_pkg::VCNT_BITS-1:0]         rsp_vertex_count
);
   import mvd_pkg::*;

   entry_type mem [TABLE_DEPTH];

   entry_type              key_ff;
   logic                   last_ff;
   logic [COUNT_BITS-1:0]  used_ff, used_in;
   logic [COUNT_BITS-1:0]  addr_ff, addr_in;
   entry_type              q_ff;
   logic                   q_valid_ff, q_valid_in;
   logic [ADDR_BITS-1:0]   q_idx_ff;
   logic                   hit_ff, hit_in;
   logic [ADDR_BITS-1:0]   hit_idx_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VIDX_BITS-1:0]   rsp_vidx_ff;
   logic                   rsp_new_ff;
   logic                   rsp_full_ff;
   logic [VCNT_BITS-1:0]   rsp_cnt_ff;

   logic                   rd_en;
   logic                   wr_en;
   logic                   key_match;
   logic                   uv_eq;
   logic                   nrm_eq;
   logic                   has_room;
   logic [COUNT_BITS-1:0]  used_after;
   logic [ADDR_BITS-1:0]   vidx_sel;

   // mode 3 falls through to the full key compare
   assign uv_eq  = (q_ff.uv == key_ff.uv);
   assign nrm_eq = (q_ff.nx == key_ff.nx) && (q_ff.ny == key_ff.ny)
                   && (q_ff.nz == key_ff.nz);
   always_comb begin
      key_match = 1'b0;
      if (q_ff.pos == key_ff.pos) begin
         case (match_mode)
            MODE_POS:    key_match = 1'b1;
            MODE_POS_UV: key_match = uv_eq;
            default:     key_match = uv_eq && nrm_eq;
         endcase
      end
   end

   assign status.match    = q_valid_ff && key_match;
   assign status.pending  = (addr_ff < used_ff) || q_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rd_en      = cmd.scan && (addr_ff < used_ff) && !status.match;
   assign has_room   = (used_ff < COUNT_BITS'(TABLE_DEPTH));
   assign wr_en      = cmd.finish && !hit_ff && has_room;
   assign used_after = used_ff + COUNT_BITS'(wr_en);
   assign vidx_sel   = hit_ff ? hit_idx_ff :
                       (has_room ? used_ff[ADDR_BITS-1:0] : '0);

   always_comb begin
      addr_in    = addr_ff;
      q_valid_in = rd_en;
      hit_in     = hit_ff;
      used_in    = used_ff;
      if (cmd.load) begin
         addr_in = '0;
         hit_in  = 1'b0;
      end
      if (rd_en) begin
         addr_in = addr_ff + COUNT_BITS'(1);
      end
      if (cmd.scan && status.match) begin
         hit_in = 1'b1;
      end
      if (cmd.finish) begin
         used_in = last_ff ? '0 : used_after;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         addr_ff      <= '0;
         q_valid_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         addr_ff      <= addr_in;
         q_valid_ff   <= q_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff.pos <= req_pos_index;
         key_ff.uv  <= req_uv_index;
         key_ff.nx  <= req_normal_x;
         key_ff.ny  <= req_normal_y;
         key_ff.nz  <= req_normal_z;
         last_ff    <= req_last_of_mesh;
      end
      if (rd_en) begin
         q_idx_ff <= addr_ff[ADDR_BITS-1:0];
      end
      if (cmd.scan && status.match) begin
         hit_idx_ff <= q_idx_ff;
      end
      if (cmd.finish) begin
         rsp_vidx_ff <= VIDX_BITS'(vidx_sel);
         rsp_new_ff  <= wr_en;
         rsp_full_ff <= !hit_ff && !has_room;
         rsp_cnt_ff  <= VCNT_BITS'(used_after);
      end
   end

   // entry table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[used_ff[ADDR_BITS-1:0]] <= key_ff;
      end
      if (rd_en) begin
         q_ff <= mem[addr_ff[ADDR_BITS-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_vidx_ff;
   assign rsp_new_vertex   = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_vertex_count = rsp_cnt_ff;

`ifndef SYNTH
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_BITS'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff |-> (COUNT_BITS'(q_idx_ff) < used_ff))
      else $error("read of an entry that was never stored");

   a_new_or_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_full_ff))
      else $error("result both new and full");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished request produced no result");

   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !q_valid_ff)
      else $error("read still in flight at new request");
`endif

endmodule

`default_nettype wire
